FILE: sv/eai_pkg.sv
// Package for the edge-aware 2x interpolator: widths, pipeline payload types and pixel math.
package eai_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int PIXEL_BITS = 3 * CHANNEL_BITS;
   // sum of three absolute channel differences
   localparam int DIFF_BITS = CHANNEL_BITS + 2;
   localparam int DEN_BITS = DIFF_BITS + 1;
   localparam int FRAC_BITS = 8;
   localparam int WEIGHT_BITS = FRAC_BITS + 1;
   localparam int PROD_BITS = CHANNEL_BITS + WEIGHT_BITS;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS_PER_STAGE;
   // input stage, diff/select stage, divider stages, output register
   localparam int NUM_STAGES = DIV_STAGES + 3;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << FRAC_BITS);
   localparam logic [WEIGHT_BITS-1:0] MID_WEIGHT = WEIGHT_BITS'(205);
   localparam logic [FRAC_BITS-1:0] QUO_MAX = FRAC_BITS'(1 << (FRAC_BITS - 1));

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef enum logic [1:0] {
      MODE_COPY  = 2'd0,
      MODE_VERT  = 2'd1,
      MODE_HORIZ = 2'd2,
      MODE_DIAG  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type mode;
      pixel_type cf;
      pixel_type aad;
      pixel_type abc;
      pixel_type a2;
      pixel_type dad_ch;
      pixel_type dbc_ch;
   } front_type;

   typedef struct packed {
      pixel_type x;
      pixel_type y;
      logic [WEIGHT_BITS-1:0] wfix;
      logic use_div;
      logic [DEN_BITS-1:0] den;
      logic [DEN_BITS-1:0] rem;
      logic [FRAC_BITS-1:0] quo;
   } div_type;

   function automatic pixel_type avg_px(input pixel_type a, input pixel_type b);
      pixel_type r;
      logic [CHANNEL_BITS:0] s;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         s = {1'b0, a[k*CHANNEL_BITS +: CHANNEL_BITS]} + {1'b0, b[k*CHANNEL_BITS +: CHANNEL_BITS]};
         r[k*CHANNEL_BITS +: CHANNEL_BITS] = s[CHANNEL_BITS:1];
      end
      return r;
   endfunction

   function automatic pixel_type absdiff_px(input pixel_type a, input pixel_type b);
      pixel_type r;
      chan_type ca;
      chan_type cb;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         ca = a[k*CHANNEL_BITS +: CHANNEL_BITS];
         cb = b[k*CHANNEL_BITS +: CHANNEL_BITS];
         r[k*CHANNEL_BITS +: CHANNEL_BITS] = (ca > cb) ? (ca - cb) : (cb - ca);
      end
      return r;
   endfunction

   function automatic logic [DIFF_BITS-1:0] sum_px(input pixel_type d);
      return DIFF_BITS'(d[0 +: CHANNEL_BITS])
         + DIFF_BITS'(d[CHANNEL_BITS +: CHANNEL_BITS])
         + DIFF_BITS'(d[2*CHANNEL_BITS +: CHANNEL_BITS]);
   endfunction

   // (x*w + y*(1-w)) per channel, weight in FRAC_BITS fixed point
   function automatic pixel_type blend_px(input pixel_type x, input pixel_type y,
                                          input logic [WEIGHT_BITS-1:0] w);
      pixel_type r;
      logic [PROD_BITS-1:0] p;
      logic [WEIGHT_BITS-1:0] wn;
      r = '0;
      wn = WEIGHT_ONE - w;
      for (int k = 0; k < 3; k++) begin
         p = PROD_BITS'(x[k*CHANNEL_BITS +: CHANNEL_BITS]) * PROD_BITS'(w)
           + PROD_BITS'(y[k*CHANNEL_BITS +: CHANNEL_BITS]) * PROD_BITS'(wn);
         r[k*CHANNEL_BITS +: CHANNEL_BITS] = p[FRAC_BITS +: CHANNEL_BITS];
      end
      return r;
   endfunction

   // restoring fraction division, a few quotient bits per call
   function automatic div_type div_step(input div_type d);
      div_type r;
      logic [DEN_BITS:0] sh;
      r = d;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         sh = {r.rem, 1'b0};
         if (sh >= {1'b0, r.den}) begin
            r.rem = DEN_BITS'(sh - {1'b0, r.den});
            r.quo = {r.quo[FRAC_BITS-2:0], 1'b1};
         end else begin
            r.rem = DEN_BITS'(sh);
            r.quo = {r.quo[FRAC_BITS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/edge_aware_2x_pixel_interpolator_core.sv
// Top level of the edge-aware 2x interpolator: one output pixel per transfer, fully pipelined.
//
// Usage:
//   req_* carries one gathered neighbourhood and its parity class (req_mode); it is taken
//   on a clock edge with req_valid and req_ready high. rsp_out_pixel is the interpolated
//   RGB888 pixel, handed over on an edge with rsp_valid and rsp_ready high.
//   Results come out in request order, exactly one per request.
// Throughput: one pixel per clock while rsp_ready is high. Every mode goes through the
//   same seven register stages: channel averages and differences, difference sums and
//   diagonal selection, four stages of the restoring divider (two weight bits each),
//   and the blend multipliers feeding the output register.
// Stall: each stage keeps its own valid bit and advances when the stage after it is
//   empty or moving, so bubbles are squeezed out and req_ready falls only when all
//   seven stages are full and rsp_ready is low. Nothing is dropped or repeated.
// Reset: synchronous, active high; clears all valid bits, so the pipe is empty and
//   req_ready is high in the first cycle after reset.
module edge_aware_2x_pixel_interpolator_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_mode,
   input  logic [eai_pkg::PIXEL_BITS-1:0] req_center_first,
   input  logic [eai_pkg::PIXEL_BITS-1:0] req_center_second,
   input  logic [eai_pkg::PIXEL_BITS-1:0] req_side_one_first,
   input  logic [eai_pkg::PIXEL_BITS-1:0] req_side_one_second,
   input  logic [eai_pkg::PIXEL_BITS-1:0] req_side_two_first,
   input  logic [eai_pkg::PIXEL_BITS-1:0] req_side_two_second,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [eai_pkg::PIXEL_BITS-1:0] rsp_out_pixel
);

   localparam int NS = eai_pkg::NUM_STAGES;
   localparam int ND = eai_pkg::DIV_STAGES;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] valid_prev;
   logic [NS:0] adv;

   eai_pkg::front_type front_ff;
   eai_pkg::front_type front_in;
   eai_pkg::div_type dv_ff [0:ND];
   eai_pkg::div_type sel_in;
   eai_pkg::pixel_type out_pixel_ff;
   eai_pkg::pixel_type out_pixel_in;
   logic [eai_pkg::WEIGHT_BITS-1:0] weight;

   logic [eai_pkg::DIFF_BITS-1:0] dad;
   logic [eai_pkg::DIFF_BITS-1:0] dbc;

   // stage k moves when it is empty or the stage after it moves
   always_comb begin
      adv[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_prev = {valid_ff[NS-2:0], req_valid};
   assign valid_in = (adv[NS-1:0] & valid_prev) | (~adv[NS-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NS-1];
   assign rsp_out_pixel = out_pixel_ff;

   // front stage: per-channel averages and absolute differences
   always_comb begin
      front_in.mode = eai_pkg::mode_type'(req_mode);
      front_in.cf = req_center_first;
      front_in.aad = eai_pkg::avg_px(req_center_first, req_center_second);
      front_in.abc = eai_pkg::avg_px(req_side_one_first, req_side_one_second);
      front_in.a2 = eai_pkg::avg_px(req_side_two_first, req_side_two_second);
      front_in.dad_ch = eai_pkg::absdiff_px(req_center_first, req_center_second);
      front_in.dbc_ch = eai_pkg::absdiff_px(req_side_one_first, req_side_one_second);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         front_ff <= front_in;
      end
   end

   // select stage: everything is reduced to blend(x, y, w); copies use w = 1.0
   assign dad = eai_pkg::sum_px(front_ff.dad_ch);
   assign dbc = eai_pkg::sum_px(front_ff.dbc_ch);

   always_comb begin
      sel_in.x = front_ff.cf;
      sel_in.y = front_ff.cf;
      sel_in.wfix = eai_pkg::WEIGHT_ONE;
      sel_in.use_div = 1'b0;
      sel_in.den = eai_pkg::DEN_BITS'(1);
      sel_in.rem = '0;
      sel_in.quo = '0;
      unique case (front_ff.mode)
         eai_pkg::MODE_COPY: begin
            sel_in.x = front_ff.cf;
         end
         eai_pkg::MODE_VERT, eai_pkg::MODE_HORIZ: begin
            sel_in.x = front_ff.aad;
            sel_in.y = eai_pkg::avg_px(front_ff.abc, front_ff.a2);
            sel_in.wfix = eai_pkg::MID_WEIGHT;
         end
         eai_pkg::MODE_DIAG: begin
            priority if (dad == '0 && dbc == '0) begin
               sel_in.x = front_ff.cf;
            end else if (dad == '0) begin
               sel_in.x = front_ff.aad;
            end else if (dbc == '0) begin
               sel_in.x = front_ff.abc;
            end else begin
               // larger-difference average gets the small/(small+large) weight
               sel_in.use_div = 1'b1;
               sel_in.den = eai_pkg::DEN_BITS'(dad) + eai_pkg::DEN_BITS'(dbc);
               if (dad < dbc) begin
                  sel_in.rem = eai_pkg::DEN_BITS'(dad);
                  sel_in.x = front_ff.abc;
                  sel_in.y = front_ff.aad;
               end else begin
                  sel_in.rem = eai_pkg::DEN_BITS'(dbc);
                  sel_in.x = front_ff.aad;
                  sel_in.y = front_ff.abc;
               end
            end
         end
         default: begin
            sel_in.x = front_ff.cf;
         end
      endcase
   end

   // select register and divider stages
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         dv_ff[0] <= sel_in;
      end
      for (int j = 1; j <= ND; j++) begin
         if (adv[1+j]) begin
            dv_ff[j] <= eai_pkg::div_step(dv_ff[j-1]);
         end
      end
   end

   // blend and output register
   assign weight = dv_ff[ND].use_div ? {1'b0, dv_ff[ND].quo} : dv_ff[ND].wfix;
   assign out_pixel_in = eai_pkg::blend_px(dv_ff[ND].x, dv_ff[ND].y, weight);

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   // the smaller sum never exceeds half of the divisor, so the weight stays at or below 1/2
   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && dv_ff[0].use_div |->
         dv_ff[0].den != '0 && {dv_ff[0].rem, 1'b0} <= {1'b0, dv_ff[0].den})
      else $error("divider operands out of range");

   a_div_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS-2] && dv_ff[ND].use_div |->
         dv_ff[ND].rem < dv_ff[ND].den && dv_ff[ND].quo <= eai_pkg::QUO_MAX)
      else $error("divider result out of range");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff) && !rsp_ready)
      else $error("request side stalled with room in the pipe");

   a_fixed_weight: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !dv_ff[0].use_div |->
         dv_ff[0].wfix == eai_pkg::WEIGHT_ONE || dv_ff[0].wfix == eai_pkg::MID_WEIGHT)
      else $error("unexpected fixed blend weight");

endmodule

FILE: tb/sv/edge_aware_2x_pixel_interpolator_core_test.sv
// Self-checking testbench for the edge-aware 2x interpolator core.
module edge_aware_2x_pixel_interpolator_core_test;

   typedef struct {
      eai_pkg::mode_type mode;
      eai_pkg::pixel_type cf;
      eai_pkg::pixel_type cs;
      eai_pkg::pixel_type s1f;
      eai_pkg::pixel_type s1s;
      eai_pkg::pixel_type s2f;
      eai_pkg::pixel_type s2s;
   } neighborhood_type;

   localparam int RANDOM_ITEMS = 850;
   localparam int CALM_LO = 300;
   localparam int CALM_HI = 420;
   localparam int HOLD_AT = 500;
   localparam int HOLD_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = '0;
   eai_pkg::pixel_type req_center_first = '0;
   eai_pkg::pixel_type req_center_second = '0;
   eai_pkg::pixel_type req_side_one_first = '0;
   eai_pkg::pixel_type req_side_one_second = '0;
   eai_pkg::pixel_type req_side_two_first = '0;
   eai_pkg::pixel_type req_side_two_second = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   eai_pkg::pixel_type rsp_out_pixel;

   neighborhood_type pending_pixels[$];
   eai_pkg::pixel_type expected_pixels[$];
   neighborhood_type offered;
   neighborhood_type next_item;
   logic offer;
   int sent_count = 0;
   int rcv_count = 0;
   int mismatch_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   edge_aware_2x_pixel_interpolator_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_center_first(req_center_first),
      .req_center_second(req_center_second),
      .req_side_one_first(req_side_one_first),
      .req_side_one_second(req_side_one_second),
      .req_side_two_first(req_side_two_first),
      .req_side_two_second(req_side_two_second),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_pixel(rsp_out_pixel)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int chan_of(eai_pkg::pixel_type p, int k);
      return int'(p[k*eai_pkg::CHANNEL_BITS +: eai_pkg::CHANNEL_BITS]);
   endfunction

   function automatic eai_pkg::pixel_type mean_px(eai_pkg::pixel_type a,
                                                  eai_pkg::pixel_type b);
      eai_pkg::pixel_type r;
      r = '0;
      for (int k = 0; k < 3; k++)
         r[k*eai_pkg::CHANNEL_BITS +: eai_pkg::CHANNEL_BITS] =
            eai_pkg::chan_type'((chan_of(a, k) + chan_of(b, k)) >> 1);
      return r;
   endfunction

   function automatic eai_pkg::pixel_type mix_px(eai_pkg::pixel_type x,
                                                 eai_pkg::pixel_type y, int w);
      eai_pkg::pixel_type r;
      r = '0;
      for (int k = 0; k < 3; k++)
         r[k*eai_pkg::CHANNEL_BITS +: eai_pkg::CHANNEL_BITS] =
            eai_pkg::chan_type'((chan_of(x, k) * w + chan_of(y, k) * (256 - w)) >> 8);
      return r;
   endfunction

   function automatic int absdiff_sum(eai_pkg::pixel_type a, eai_pkg::pixel_type b);
      int s;
      int ca;
      int cb;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         ca = chan_of(a, k);
         cb = chan_of(b, k);
         s += (ca > cb) ? ca - cb : cb - ca;
      end
      return s;
   endfunction

   function automatic eai_pkg::pixel_type interp_pixel(neighborhood_type n);
      int dad;
      int dbc;
      int w;
      eai_pkg::pixel_type aad;
      eai_pkg::pixel_type abc;
      case (n.mode)
         eai_pkg::MODE_COPY: begin
            return n.cf;
         end
         eai_pkg::MODE_VERT, eai_pkg::MODE_HORIZ: begin
            return mix_px(mean_px(n.cf, n.cs),
                          mean_px(mean_px(n.s1f, n.s1s), mean_px(n.s2f, n.s2s)),
                          int'(eai_pkg::MID_WEIGHT));
         end
         default: begin
            dad = absdiff_sum(n.cf, n.cs);
            dbc = absdiff_sum(n.s1f, n.s1s);
            aad = mean_px(n.cf, n.cs);
            abc = mean_px(n.s1f, n.s1s);
            if (dad == 0 && dbc == 0) return n.cf;
            if (dad == 0) return aad;
            if (dbc == 0) return abc;
            // weight goes to the rougher diagonal; a tie counts the B-C diagonal as smoother
            if (dad < dbc) begin
               w = (256 * dad) / (dad + dbc);
               return mix_px(abc, aad, w);
            end
            w = (256 * dbc) / (dad + dbc);
            return mix_px(aad, abc, w);
         end
      endcase
   endfunction

   function automatic eai_pkg::pixel_type rand_px();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return eai_pkg::pixel_type'($urandom);
   endfunction

   // small per-channel perturbation, keeps diagonal sums low
   function automatic eai_pkg::pixel_type near_px(eai_pkg::pixel_type p);
      return p ^ eai_pkg::pixel_type'($urandom & 32'h0003_0303);
   endfunction

   task automatic add_item(eai_pkg::mode_type m, eai_pkg::pixel_type cf,
                           eai_pkg::pixel_type cs, eai_pkg::pixel_type s1f,
                           eai_pkg::pixel_type s1s, eai_pkg::pixel_type s2f,
                           eai_pkg::pixel_type s2s);
      neighborhood_type n;
      n.mode = m;
      n.cf = cf;
      n.cs = cs;
      n.s1f = s1f;
      n.s1s = s1s;
      n.s2f = s2f;
      n.s2s = s2s;
      pending_pixels.push_back(n);
   endtask

   task automatic add_random_item();
      int r;
      int shape;
      eai_pkg::pixel_type a;
      eai_pkg::pixel_type b;
      eai_pkg::pixel_type c;
      eai_pkg::pixel_type d;
      r = $urandom_range(0, 5);
      if (r < 3) begin
         add_item(eai_pkg::mode_type'(r), rand_px(), rand_px(), rand_px(), rand_px(),
                  rand_px(), rand_px());
         return;
      end
      a = rand_px();
      b = rand_px();
      c = rand_px();
      d = rand_px();
      shape = $urandom_range(0, 9);
      case (shape)
         0: d = a;
         1: c = b;
         2: begin
            d = a;
            c = b;
         end
         3: begin
            d = near_px(a);
            c = near_px(b);
         end
         4: d = near_px(a);
         5: c = near_px(b);
         6: begin
            // identical diagonals give equal sums
            b = a;
            c = d;
         end
         default: ;
      endcase
      add_item(eai_pkg::MODE_DIAG, a, d, b, c, rand_px(), rand_px());
   endtask

   function automatic bit sender_idles();
      if (sent_count >= CALM_LO && sent_count < CALM_HI) return 1'b0;
      return $urandom_range(0, 99) < 36;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(interp_pixel(offered));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            offer = pending_pixels.size() > 0 && !sender_idles();
            if (offer) begin
               next_item = pending_pixels.pop_front();
               offered = next_item;
               req_mode <= next_item.mode;
               req_center_first <= next_item.cf;
               req_center_second <= next_item.cs;
               req_side_one_first <= next_item.s1f;
               req_side_one_second <= next_item.s1s;
               req_side_two_first <= next_item.s2f;
               req_side_two_second <= next_item.s2s;
            end
            req_valid <= offer;
         end
      end
   end

   always @(posedge clock) begin
      eai_pkg::pixel_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rcv_count++;
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transfer, expected none, got out_pixel %06h",
                        $time, rsp_out_pixel);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_out_pixel !== want) begin
                  mismatch_count++;
                  $display("%0t: out_pixel mismatch, expected %06h, got %06h",
                           $time, want, rsp_out_pixel);
               end
            end
         end
         // one long back-pressure stretch so the pipe fills and req_ready drops
         if (!hold_done && rcv_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rcv_count >= CALM_LO && rcv_count < CALM_HI) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >= 36;
         end
      end
   end

   initial begin
      // copy
      add_item(eai_pkg::MODE_COPY, '0, '1, '1, '1, '1, '1);
      add_item(eai_pkg::MODE_COPY, '1, '0, '0, '0, '0, '0);
      add_item(eai_pkg::MODE_COPY, 24'h123456, 24'hfedcba, 24'h00ff00, 24'hff00ff,
               24'h0f0f0f, 24'hf0f0f0);
      // midpoints
      add_item(eai_pkg::MODE_VERT, '0, '0, '0, '0, '0, '0);
      add_item(eai_pkg::MODE_VERT, '1, '1, '1, '1, '1, '1);
      add_item(eai_pkg::MODE_VERT, '1, '0, '0, '1, '1, '0);
      add_item(eai_pkg::MODE_HORIZ, '1, '1, '0, '0, '0, '0);
      add_item(eai_pkg::MODE_HORIZ, '0, '0, '1, '1, '1, '1);
      add_item(eai_pkg::MODE_HORIZ, 24'h800000, 24'h007f01, 24'hff0080, 24'h01fe7f,
               24'h55aa55, 24'haa55aa);
      // diagonals: both flat
      add_item(eai_pkg::MODE_DIAG, '0, '0, '0, '0, '1, '1);
      add_item(eai_pkg::MODE_DIAG, 24'h123456, 24'h123456, 24'habcdef, 24'habcdef, '0, '1);
      // one flat diagonal
      add_item(eai_pkg::MODE_DIAG, 24'h204060, 24'h204060, 24'hff0000, 24'h00ff00, '0, '0);
      add_item(eai_pkg::MODE_DIAG, 24'hff0000, 24'h00ff00, 24'h204060, 24'h204060, '0, '0);
      // tie between diagonals
      add_item(eai_pkg::MODE_DIAG, '0, 24'h010101, '1, 24'hfefefe, '0, '0);
      add_item(eai_pkg::MODE_DIAG, '0, '1, '1, '0, '1, '0);
      // unequal, both directions
      add_item(eai_pkg::MODE_DIAG, '0, 24'h000001, '0, '1, '0, '0);
      add_item(eai_pkg::MODE_DIAG, '0, '1, '1, 24'hfffffe, '0, '0);
      add_item(eai_pkg::MODE_DIAG, '1, '0, 24'h808080, 24'h7f7f7f, '1, '1);
      add_item(eai_pkg::MODE_DIAG, 24'h10ff10, 24'hff10ff, 24'h3c3c3c, 24'h3d3b3c, '0, '0);
      add_item(eai_pkg::MODE_DIAG, 24'h7f7f7f, 24'h808080, '1, 24'h00ff00, '1, '0);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         add_random_item();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
